>>> src/olm_pkg.sv
// Package for the operator longest-match block: operator codes, shared types
// and the trie transition function. No dependencies.
package olm_pkg;

  localparam int NumOps   = 41;
  localparam int PrintLow = 32;
  localparam int PrintEnd = 128;

  localparam logic [5:0] OpAssign    = 6'd0;
  localparam logic [5:0] OpAddAssign = 6'd1;
  localparam logic [5:0] OpSubAssign = 6'd2;
  localparam logic [5:0] OpMulAssign = 6'd3;
  localparam logic [5:0] OpDivAssign = 6'd4;
  localparam logic [5:0] OpModAssign = 6'd5;
  localparam logic [5:0] OpShlAssign = 6'd6;
  localparam logic [5:0] OpShrAssign = 6'd7;
  localparam logic [5:0] OpAndAssign = 6'd8;
  localparam logic [5:0] OpOrAssign  = 6'd9;
  localparam logic [5:0] OpXorAssign = 6'd10;
  localparam logic [5:0] OpAdd       = 6'd11;
  localparam logic [5:0] OpSub       = 6'd12;
  localparam logic [5:0] OpMul       = 6'd13;
  localparam logic [5:0] OpDiv       = 6'd14;
  localparam logic [5:0] OpMod       = 6'd15;
  localparam logic [5:0] OpShl       = 6'd16;
  localparam logic [5:0] OpShr       = 6'd17;
  localparam logic [5:0] OpBitAnd    = 6'd18;
  localparam logic [5:0] OpBitOr     = 6'd19;
  localparam logic [5:0] OpXor       = 6'd20;
  localparam logic [5:0] OpLogAnd    = 6'd21;
  localparam logic [5:0] OpLogOr     = 6'd22;
  localparam logic [5:0] OpNot       = 6'd23;
  localparam logic [5:0] OpBitNot    = 6'd24;
  localparam logic [5:0] OpDec       = 6'd25;
  localparam logic [5:0] OpInc       = 6'd26;
  localparam logic [5:0] OpEq        = 6'd27;
  localparam logic [5:0] OpNe        = 6'd28;
  localparam logic [5:0] OpLt        = 6'd29;
  localparam logic [5:0] OpLe        = 6'd30;
  localparam logic [5:0] OpGt        = 6'd31;
  localparam logic [5:0] OpGe        = 6'd32;
  localparam logic [5:0] OpQuest     = 6'd33;
  localparam logic [5:0] OpColon     = 6'd34;
  localparam logic [5:0] OpSemi      = 6'd35;
  localparam logic [5:0] OpComma     = 6'd36;
  localparam logic [5:0] OpLParen    = 6'd37;
  localparam logic [5:0] OpRParen    = 6'd38;
  localparam logic [5:0] OpLBrack    = 6'd39;
  localparam logic [5:0] OpRBrack    = 6'd40;

  typedef struct packed {
    logic       hit;
    logic [5:0] code;
  } step_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] code;
    logic [1:0] len;
    logic       found;
  } emit_t;

  function automatic step_t olm_child(logic [1:0] pos, logic [5:0] node, logic [7:0] c);
    step_t s;
    s.hit  = 1'b0;
    s.code = OpAssign;
    if ((32'(c) >= PrintLow) && (32'(c) < PrintEnd)) begin
      case (pos)
        2'd0: begin
          s.hit = 1'b1;
          case (c)
            "=": s.code = OpAssign;
            "+": s.code = OpAdd;
            "-": s.code = OpSub;
            "*": s.code = OpMul;
            "/": s.code = OpDiv;
            "%": s.code = OpMod;
            "&": s.code = OpBitAnd;
            "|": s.code = OpBitOr;
            "^": s.code = OpXor;
            "!": s.code = OpNot;
            "~": s.code = OpBitNot;
            "<": s.code = OpLt;
            ">": s.code = OpGt;
            "?": s.code = OpQuest;
            ":": s.code = OpColon;
            ";": s.code = OpSemi;
            ",": s.code = OpComma;
            "(": s.code = OpLParen;
            ")": s.code = OpRParen;
            "[": s.code = OpLBrack;
            "]": s.code = OpRBrack;
            default: s.hit = 1'b0;
          endcase
        end
        2'd1: begin
          s.hit = 1'b1;
          case (node)
            OpAssign: if (c == "=") s.code = OpEq; else s.hit = 1'b0;
            OpAdd: begin
              if (c == "=") s.code = OpAddAssign;
              else if (c == "+") s.code = OpInc;
              else s.hit = 1'b0;
            end
            OpSub: begin
              if (c == "=") s.code = OpSubAssign;
              else if (c == "-") s.code = OpDec;
              else s.hit = 1'b0;
            end
            OpMul: if (c == "=") s.code = OpMulAssign; else s.hit = 1'b0;
            OpDiv: if (c == "=") s.code = OpDivAssign; else s.hit = 1'b0;
            OpMod: if (c == "=") s.code = OpModAssign; else s.hit = 1'b0;
            OpLt: begin
              if (c == "<") s.code = OpShl;
              else if (c == "=") s.code = OpLe;
              else s.hit = 1'b0;
            end
            OpGt: begin
              if (c == ">") s.code = OpShr;
              else if (c == "=") s.code = OpGe;
              else s.hit = 1'b0;
            end
            OpBitAnd: begin
              if (c == "=") s.code = OpAndAssign;
              else if (c == "&") s.code = OpLogAnd;
              else s.hit = 1'b0;
            end
            OpBitOr: begin
              if (c == "=") s.code = OpOrAssign;
              else if (c == "|") s.code = OpLogOr;
              else s.hit = 1'b0;
            end
            OpXor: if (c == "=") s.code = OpXorAssign; else s.hit = 1'b0;
            OpNot: if (c == "=") s.code = OpNe; else s.hit = 1'b0;
            default: s.hit = 1'b0;
          endcase
        end
        2'd2: begin
          if (node == OpShl && c == "=") begin
            s.hit  = 1'b1;
            s.code = OpShlAssign;
          end else if (node == OpShr && c == "=") begin
            s.hit  = 1'b1;
            s.code = OpShrAssign;
          end
        end
        default: s.hit = 1'b0;
      endcase
    end
    return s;
  endfunction

endpackage

>>> src/olm_walk.sv
// Trie walk state and one-step transition for the operator matcher.
// Depends on olm_pkg (olm_child, emit_t).
module olm_walk import olm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] character,
  input  logic       last,
  output emit_t      res
);

  logic [5:0] trie_node, trie_node_next;
  logic [5:0] best_operator, best_operator_next;
  logic [1:0] best_length, best_length_next;
  logic [1:0] position, position_next;
  logic       walk_done, walk_done_next;
  step_t      child;

  always_comb begin
    child              = olm_child(position, trie_node, character);
    trie_node_next     = trie_node;
    best_operator_next = best_operator;
    best_length_next   = best_length;
    position_next      = position;
    walk_done_next     = walk_done;
    res.valid          = 1'b0;
    res.code           = best_operator;
    res.len            = best_length;
    res.found          = (best_length != 2'd0);
    if (step) begin
      if (walk_done) begin
        if (last) begin
          walk_done_next   = 1'b0;
          position_next    = 2'd0;
          best_length_next = 2'd0;
          best_operator_next = OpAssign;
          trie_node_next   = OpAssign;
        end
      end else if (!child.hit) begin
        res.valid = 1'b1;
        if (last) begin
          position_next      = 2'd0;
          best_length_next   = 2'd0;
          best_operator_next = OpAssign;
          trie_node_next     = OpAssign;
        end else begin
          walk_done_next = 1'b1;
        end
      end else begin
        trie_node_next     = child.code;
        position_next      = position + 2'd1;
        best_operator_next = child.code;
        best_length_next   = position + 2'd1;
        if (last) begin
          res.valid          = 1'b1;
          res.code           = child.code;
          res.len            = position + 2'd1;
          res.found          = 1'b1;
          position_next      = 2'd0;
          best_length_next   = 2'd0;
          best_operator_next = OpAssign;
          trie_node_next     = OpAssign;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trie_node     <= OpAssign;
      best_operator <= OpAssign;
      best_length   <= 2'd0;
      position      <= 2'd0;
      walk_done     <= 1'b0;
    end else begin
      trie_node     <= trie_node_next;
      best_operator <= best_operator_next;
      best_length   <= best_length_next;
      position      <= position_next;
      walk_done     <= walk_done_next;
    end
  end

`ifndef SYNTH
  a_root_empty: assert property (@(posedge clk) disable iff (rst)
    position == 2'd0 |-> best_length == 2'd0)
    else $error("best match held at trie root");
  a_node_best: assert property (@(posedge clk) disable iff (rst)
    position != 2'd0 |-> best_length == position && best_operator == trie_node)
    else $error("best match out of step with trie node");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    step && last |=> position == 2'd0 && !walk_done)
    else $error("walk not cleared after last item");
`endif

endmodule

>>> src/operator_longest_match.sv
// Top level of the operator longest-match block: input register, trie walk,
// result register. Depends on olm_pkg and olm_walk.
//
//   channel | handshake           | payload
//   input   | in_valid, in_ready   | character[7:0], last
//   output  | out_valid, out_ready | operator_code[5:0], match_length[1:0], found
//
// One item per cycle unless the output stalls; a result passes both registers.
// The trie step is a single lookup between the input and result registers.
// in_ready drops only while the result register is full and not taken.
// Synchronous reset returns the walk to the trie root and empties both registers.
module operator_longest_match import olm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] character,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] operator_code,
  output logic [1:0] match_length,
  output logic       found
);

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       adv;
  logic       s1_fire;
  emit_t      res;

  assign adv      = !out_valid || out_ready;
  assign s1_fire  = s1_valid && adv;
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char <= character;
      s1_last <= last;
    end
  end

  olm_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_fire),
    .character (s1_char),
    .last      (s1_last),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res.valid) begin
      operator_code <= res.code;
      match_length  <= res.len;
      found         <= res.found;
    end
  end

`ifndef SYNTH
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");
  a_found_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> found == (match_length != 2'd0))
    else $error("found flag disagrees with match length");
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(operator_code) < NumOps)
    else $error("operator code out of range");
`endif

endmodule
